// ===== rtl/core/olla_pkg.sv =====
// olla_pkg: shared widths, types and state encoding for the outer-loop link
// offset update unit. No dependencies; imported by every module in rtl/core.
package olla_pkg;

    localparam int MAX_BLOCKS = 8;    // blocks per slot, count saturates here
    localparam int FLAG_W     = 8;    // fail flag vector width
    localparam int CNT_W      = 4;    // block count / slot failures width
    localparam int STEP_W     = 20;   // step_up / step_down width
    localparam int LIM_W      = 23;   // clamp limit width
    localparam int OFS_W      = 24;   // Q8.16 offset width (signed)
    localparam int TOT_W      = 32;   // running totals width
    localparam int PROD_W     = STEP_W + CNT_W;   // step * blocks
    localparam int NUM_W      = PROD_W + 1;       // signed numerator
    localparam int DIV_W      = PROD_W;           // dividend magnitude width
    localparam int DIVS_W     = CNT_W;            // divisor width
    localparam int SUM_W      = OFS_W + 2;        // offset + quotient, signed
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFS_W;
    localparam int S_TDATA_W  = 16;   // fail_flags + block_count, byte padded
    localparam int M_TDATA_W  = 96;   // 24 + 4 + 32 + 32, byte padded

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_UP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd3;

    localparam logic [STEP_W-1:0] STEP_UP_RST    = 20'd7282;
    localparam logic [STEP_W-1:0] STEP_DOWN_RST  = 20'd65536;
    localparam logic [LIM_W-1:0]  CLAMP_RST      = 23'd655360;
    localparam logic [OFS_W-1:0]  START_OFS_RST  = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } olla_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/outer_loop_link_offset_update_unit.sv =====
// Outer-loop link adaptation offset update, top level.
// Depends on olla_pkg and olla_div.
//
// One input transfer carries a slot's CRC verdicts (fail flags and block
// count). The unit counts failed blocks, forms (step_up*passes -
// step_down*fails), divides it by the block count with truncation toward
// zero, adds the quotient to the Q8.16 offset and clamps the sum to
// +/- clamp_limit. Block and failure totals saturate at 2^32-1. A zero count
// leaves offset and totals as they are but still returns a result. One
// result transfer follows every input transfer. A slot with a nonzero count
// passes from accept to result valid through a product step, a subtract
// step, the serial divider (one quotient bit a cycle), a step that captures
// the quotient, an update step and the output load; a zero count goes
// straight to the output load. The next slot can be accepted in the cycle
// after the result is loaded. The output load waits while the previous
// result is still held unaccepted. The unit holds s_tready low while a
// slot is in flight, and the result sits in an output register so the
// next slot may be accepted before it is taken.
// Writing start_offset reloads the offset and clears both totals; writes are
// expected only while the unit is idle.
module outer_loop_link_offset_update_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [olla_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [olla_pkg::CFG_DATA_W-1:0]       cfg_data,
    // slot input: [7:0] fail_flags, [11:8] block_count, [15:12] zero
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [olla_pkg::S_TDATA_W-1:0]        s_tdata,
    // result: [23:0] new_offset, [27:24] slot_failures,
    //         [59:28] total_blocks, [91:60] total_failures, [95:92] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [olla_pkg::M_TDATA_W-1:0]        m_tdata
);
    import olla_pkg::*;

    // config registers
    logic [STEP_W-1:0] step_up_reg;
    logic [STEP_W-1:0] step_down_reg;
    logic [LIM_W-1:0]  clamp_reg;

    // running state
    logic signed [OFS_W-1:0] offset_reg, offset_next;
    logic [TOT_W-1:0]        blocks_reg, blocks_next;
    logic [TOT_W-1:0]        fails_tot_reg, fails_tot_next;

    // per-slot working registers
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  fails_reg;
    logic [PROD_W-1:0] up_reg;
    logic [PROD_W-1:0] down_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  quo_reg;

    // sequencer
    olla_state_t state_reg, state_next;
    logic        out_free;
    logic        load_slot, load_prod, load_quo, do_update, load_out;
    logic        div_start;

    // input decode
    logic [FLAG_W-1:0] in_flags;
    logic [CNT_W-1:0]  in_count;
    logic [CNT_W-1:0]  count_sat;
    logic [CNT_W-1:0]  fails_cnt;
    int                i;

    // arithmetic
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_mag;
    logic signed [DIV_W:0]   quo_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;
    logic signed [SUM_W-1:0] clamped;
    logic [TOT_W:0]          blocks_sum;
    logic [TOT_W:0]          fails_sum;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign cfg_ready = 1'b1;

    // ---- input decode: saturate count, count failures among valid blocks
    assign in_flags  = s_tdata[FLAG_W-1:0];
    assign in_count  = s_tdata[FLAG_W +: CNT_W];
    assign count_sat = (in_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : in_count;

    always_comb begin
        fails_cnt = '0;
        for (i = 0; i < FLAG_W; i++) begin
            if (in_flags[i] && (CNT_W'(i) < count_sat)) begin
                fails_cnt = fails_cnt + CNT_W'(1);
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // ---- sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (count_sat == '0) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        load_slot = 1'b0;
        load_prod = 1'b0;
        load_quo  = 1'b0;
        do_update = 1'b0;
        load_out  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                load_slot = s_tvalid;
            end
            ST_MUL:  load_prod = 1'b1;
            ST_SUB:  div_start = 1'b1;
            ST_DIV:  load_quo = div_rsp.done;
            ST_UPD:  do_update = 1'b1;
            ST_OUT:  load_out = out_free;
            default: ;
        endcase
    end

    // ---- numerator magnitude feeds the divider, its sign is registered at start
    assign num     = $signed({1'b0, up_reg}) - $signed({1'b0, down_reg});
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    assign div_req.start    = div_start;
    assign div_req.dividend = num_mag[DIV_W-1:0];
    assign div_req.divisor  = count_reg;

    olla_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---- offset update with symmetric clamp, saturating totals
    assign quo_s   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sum     = SUM_W'(offset_reg) + SUM_W'(quo_s);
    assign lim_pos = $signed({{(SUM_W-LIM_W){1'b0}}, clamp_reg});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum > lim_pos) begin
            clamped = lim_pos;
        end else if (sum < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = sum;
        end
    end

    assign blocks_sum = {1'b0, blocks_reg} + (TOT_W + 1)'(count_reg);
    assign fails_sum  = {1'b0, fails_tot_reg} + (TOT_W + 1)'(fails_reg);

    always_comb begin
        offset_next    = offset_reg;
        blocks_next    = blocks_reg;
        fails_tot_next = fails_tot_reg;
        if (cfg_valid && cfg_ready && (cfg_index == REG_START_OFFSET)) begin
            offset_next    = $signed(cfg_data);
            blocks_next    = '0;
            fails_tot_next = '0;
        end else if (do_update) begin
            offset_next    = clamped[OFS_W-1:0];
            blocks_next    = blocks_sum[TOT_W] ? '1 : blocks_sum[TOT_W-1:0];
            fails_tot_next = fails_sum[TOT_W] ? '1 : fails_sum[TOT_W-1:0];
        end
    end

    // ---- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_up_reg   <= STEP_UP_RST;
            step_down_reg <= STEP_DOWN_RST;
            clamp_reg     <= CLAMP_RST;
            offset_reg    <= $signed(START_OFS_RST);
            blocks_reg    <= '0;
            fails_tot_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            blocks_reg    <= blocks_next;
            fails_tot_reg <= fails_tot_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STEP_UP:     step_up_reg   <= cfg_data[STEP_W-1:0];
                    REG_STEP_DOWN:   step_down_reg <= cfg_data[STEP_W-1:0];
                    REG_CLAMP_LIMIT: clamp_reg     <= cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (load_slot) begin
            count_reg <= count_sat;
            fails_reg <= (count_sat == '0) ? '0 : fails_cnt;
        end
        if (load_prod) begin
            up_reg   <= PROD_W'(step_up_reg) * PROD_W'(count_reg - fails_reg);
            down_reg <= PROD_W'(step_down_reg) * PROD_W'(fails_reg);
        end
        if (div_start) begin
            neg_reg <= num[NUM_W-1];
        end
        if (load_quo) begin
            quo_reg <= div_rsp.quotient;
        end
        if (load_out) begin
            m_tdata_reg <= {
                {(M_TDATA_W - OFS_W - CNT_W - 2 * TOT_W){1'b0}},
                fails_tot_reg,
                blocks_reg,
                fails_reg,
                offset_reg
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/olla_div.sv =====
// olla_div: restoring bit-serial unsigned divider, one quotient bit a cycle.
// Depends on olla_pkg for widths and the request/response structs.
module olla_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  olla_pkg::div_req_t req,
    output olla_pkg::div_rsp_t rsp
);
    import olla_pkg::*;

    localparam int ITER_W = $clog2(DIV_W + 1);

    logic                busy_reg, busy_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0]   dvs_reg, dvs_next;
    logic                done_reg, done_next;
    logic [DIVS_W:0]     shifted;
    logic [DIVS_W:0]     trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            iter_next = ITER_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits DIVS_W bits
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/olla_checker.sv =====
// olla_checker: port-level assertions for the offset update unit, bound to
// the top level. Depends on olla_pkg and outer_loop_link_offset_update_unit.
module olla_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [olla_pkg::M_TDATA_W-1:0]        m_tdata
);
    import olla_pkg::*;

    // a held result keeps its valid
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // one slot in flight: no accept right after an accept
    a_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a slot is in flight");

    // slot failures never exceed the block limit
    a_slot_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[27:24] <= CNT_W'(MAX_BLOCKS)))
        else $error("slot failure count out of range");

    // failure total never exceeds block total
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[91:60] <= m_tdata[59:28]))
        else $error("failure total above block total");

endmodule

bind outer_loop_link_offset_update_unit olla_checker u_olla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
